// ===== hdl/blr_pkg.sv =====
package blr_pkg;

    // fixed field widths
    localparam int COORD_W = 6;
    localparam int ERR_W   = 9;
    localparam int DELTA_W = 8;

    // longest run a single segment can produce
    localparam int MAX_RUN = 64;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } segment_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
        logic   bad_segment;
    } pixel_t;

    // classified segment handed from front to back
    typedef struct packed {
        logic                     bad;
        coord_t                   x;
        coord_t                   y;
        logic signed [ERR_W-1:0]  err;
        logic [DELTA_W-1:0]       twice_dx;
        logic [DELTA_W-1:0]       twice_dy;
        coord_t                   last_count;
    } cmd_t;

endpackage

// ===== hdl/blr_front.sv =====
module blr_front
    import blr_pkg::*;
#(
    parameter int GRID_SIZE = 64
)
(
    input  segment_t seg,
    output cmd_t     cmd
);

    // run length is capped by the grid and by the longest possible run
    localparam int LIMIT = (GRID_SIZE < MAX_RUN) ? GRID_SIZE : MAX_RUN;
    localparam coord_t LAST_MAX = COORD_W'(LIMIT - 1);

    logic [COORD_W:0]   dx_ext;
    logic [COORD_W:0]   dy_ext;
    coord_t             dx;
    coord_t             dy;
    logic               bad;

    // deltas with borrow bit to detect reversed endpoints
    assign dx_ext = {1'b0, seg.x_end} - {1'b0, seg.x_start};
    assign dy_ext = {1'b0, seg.y_end} - {1'b0, seg.y_start};
    assign dx     = dx_ext[COORD_W-1:0];
    assign dy     = dy_ext[COORD_W-1:0];

    // outside the first octant
    assign bad = dx_ext[COORD_W] | dy_ext[COORD_W] | (dy > dx);

    // command fields: bad flag, start point, initial decision term, doubled deltas and capped run count
    always_comb
    begin
        cmd.bad        = bad;
        cmd.x          = seg.x_start;
        cmd.y          = seg.y_start;
        cmd.twice_dx   = {1'b0, dx, 1'b0};
        cmd.twice_dy   = {1'b0, dy, 1'b0};
        cmd.err        = $signed({2'b00, dy, 1'b0}) - $signed({3'b000, dx});
        cmd.last_count = (dx > LAST_MAX) ? LAST_MAX : dx;
    end

endmodule

// ===== hdl/blr_queue.sv =====
module blr_queue
    import blr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_data,
    output logic full,
    input  logic pop,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = mem[rd_ptr_reg];

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/blr_back.sv =====
module blr_back
    import blr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  logic   cmd_empty,
    output logic   cmd_pop,
    output pixel_t pix,
    output logic   empty,
    input  logic   pop
);

    logic                     busy_reg;
    coord_t                   cur_x_reg;
    coord_t                   cur_y_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [DELTA_W-1:0]       tdx_reg;
    logic [DELTA_W-1:0]       tdy_reg;
    coord_t                   remain_reg;
    pixel_t                   out_reg;
    logic                     out_valid_reg;

    logic                     out_free;
    logic                     emit;
    logic                     last;
    logic signed [ERR_W-1:0]  err_next;

    // output slot can take a new result this cycle
    assign out_free = ~out_valid_reg | pop;
    assign emit     = busy_reg & out_free;
    assign last     = (remain_reg == '0);
    assign cmd_pop  = ~busy_reg & ~cmd_empty & out_free;
    assign empty    = ~out_valid_reg;
    assign pix      = out_reg;

    // decision step: step y when the error term is non-negative
    always_comb
    begin
        if (!err_reg[ERR_W-1])
        begin
            err_next = err_reg - $signed({1'b0, tdx_reg}) + $signed({1'b0, tdy_reg});
        end
        else
        begin
            err_next = err_reg + $signed({1'b0, tdy_reg});
        end
    end

    // stepper control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (cmd_pop)
            begin
                busy_reg      <= ~cmd.bad;
                out_valid_reg <= cmd.bad;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stepper datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg    <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            err_reg    <= '0;
            tdx_reg    <= '0;
            tdy_reg    <= '0;
            remain_reg <= '0;
        end
        else if (emit)
        begin
            out_reg.pixel_x     <= cur_x_reg;
            out_reg.pixel_y     <= cur_y_reg;
            out_reg.last_pixel  <= last;
            out_reg.bad_segment <= 1'b0;
            cur_x_reg           <= cur_x_reg + 1'b1;
            cur_y_reg           <= err_reg[ERR_W-1] ? cur_y_reg : cur_y_reg + 1'b1;
            err_reg             <= err_next;
            remain_reg          <= remain_reg - 1'b1;
        end
        else if (cmd_pop)
        begin
            cur_x_reg  <= cmd.x;
            cur_y_reg  <= cmd.y;
            err_reg    <= cmd.err;
            tdx_reg    <= cmd.twice_dx;
            tdy_reg    <= cmd.twice_dy;
            remain_reg <= cmd.last_count;
            if (cmd.bad)
            begin
                out_reg.pixel_x     <= '0;
                out_reg.pixel_y     <= '0;
                out_reg.last_pixel  <= 1'b1;
                out_reg.bad_segment <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/bresenham_line_rasterizer.sv =====
// a segment is written into the queue, then loaded into the stepper, then its
//   first pixel is registered (a bad segment's result is registered at load)
// throughput: one pixel per cycle from the stepper while pop frees the result
//   slot, plus a load step per segment (a bad segment has only the load step)
// a two-entry command queue lets new segments transfer in while one is drawn
// reset: rst_n clears the queue, the stepper and the result register at once
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int GRID_SIZE = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  segment_t seg,
    output logic     empty,
    input  logic     pop,
    output pixel_t   pix
);

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_empty;
    logic queue_pop;

    // classify incoming segments
    blr_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .seg (seg),
        .cmd (front_cmd)
    );

    // decouple front from stepper
    blr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .full    (full),
        .pop     (queue_pop),
        .rd_data (queue_cmd),
        .empty   (queue_empty)
    );

    // pixel stepper and result register
    blr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_empty (queue_empty),
        .cmd_pop   (queue_pop),
        .pix       (pix),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ===== dv/blr_checker.sv =====
module blr_checker
    import blr_pkg::*;
#(
    parameter int GRID_SIZE = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  segment_t seg,
    input  logic     empty,
    input  logic     pop,
    input  pixel_t   pix,
    output int       fail_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // keep the log readable when the block is badly broken
    localparam int REPORT_CAP = 60;

    // pixels still owed by the block, oldest first
    pixel_t expected_pixels[$];
    int     miss_total = 0;

    // stepper state mirrored after each drawable segment
    coord_t                  run_x        = '0;
    coord_t                  run_y        = '0;
    logic signed [ERR_W-1:0] run_err      = '0;
    coord_t                  run_stop_x   = '0;
    logic [DELTA_W-1:0]      run_twice_dx = '0;
    logic [DELTA_W-1:0]      run_twice_dy = '0;

    // walk one segment with the error-term rule and queue its pixels
    task automatic rasterize_segment(input segment_t s);
        int     dx;
        int     dy;
        int     d;
        int     px;
        int     py;
        int     run_len;
        int     cap;
        pixel_t p;
        dx = int'(s.x_end) - int'(s.x_start);
        dy = int'(s.y_end) - int'(s.y_start);
        // outside the first octant: one flagged result, state untouched
        if (dx < 0 || dy < 0 || dy > dx)
        begin
            p.pixel_x     = '0;
            p.pixel_y     = '0;
            p.last_pixel  = 1'b1;
            p.bad_segment = 1'b1;
            expected_pixels.push_back(p);
            return;
        end
        cap     = (GRID_SIZE < MAX_RUN) ? GRID_SIZE : MAX_RUN;
        run_len = (dx + 1 > cap) ? cap : dx + 1;
        d       = 2 * dy - dx;
        px      = int'(s.x_start);
        py      = int'(s.y_start);
        run_stop_x   = s.x_end;
        run_twice_dx = DELTA_W'(2 * dx);
        run_twice_dy = DELTA_W'(2 * dy);
        for (int n = 0; n < run_len; n++)
        begin
            p.pixel_x     = COORD_W'(px);
            p.pixel_y     = COORD_W'(py);
            p.last_pixel  = (n == run_len - 1);
            p.bad_segment = 1'b0;
            expected_pixels.push_back(p);
            // decide first, then add the row delta
            if (d >= 0)
            begin
                py++;
                d -= 2 * dx;
            end
            d += 2 * dy;
            px++;
        end
        run_x   = COORD_W'(px);
        run_y   = COORD_W'(py);
        run_err = ERR_W'(d);
    endtask

    task automatic report_field(input string field, input int want, input int got);
        miss_total++;
        if (miss_total <= REPORT_CAP)
            $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // compare one popped pixel with the oldest expectation
    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            miss_total++;
            if (miss_total <= REPORT_CAP)
                $error("pixel transfer with nothing expected: x %0d y %0d",
                       got.pixel_x, got.pixel_y);
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_x !== want.pixel_x)
            report_field("pixel_x", want.pixel_x, got.pixel_x);
        if (got.pixel_y !== want.pixel_y)
            report_field("pixel_y", want.pixel_y, got.pixel_y);
        if (got.last_pixel !== want.last_pixel)
            report_field("last_pixel", want.last_pixel, got.last_pixel);
        if (got.bad_segment !== want.bad_segment)
            report_field("bad_segment", want.bad_segment, got.bad_segment);
    endtask

    // sample both channels at the edge, results before new segments
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_pixel(pix);
            if (push && !full)
                rasterize_segment(seg);
        end
        pending    <= expected_pixels.size();
        fail_count <= miss_total;
    end

endmodule

// ===== dv/tb_bresenham_line_rasterizer.sv =====
module tb_bresenham_line_rasterizer
    import blr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_SIZE    = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_ITEMS   = 94;
    localparam int STEADY_ITEMS = 40;
    localparam int SEG_W        = $bits(segment_t);

    typedef enum int
    {
        SEG_OCTANT,
        SEG_NOISE,
        SEG_BACKWARD,
        SEG_DESCENDING,
        SEG_STEEP
    } seg_kind_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     push;
    logic     full;
    segment_t seg;
    logic     empty;
    logic     pop;
    pixel_t   pix;
    int       fail_count;
    int       pending;
    int       cycle_count = 0;
    bit       idle_on = 1'b1;

    bresenham_line_rasterizer #(.GRID_SIZE(GRID_SIZE)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .seg   (seg),
        .empty (empty),
        .pop   (pop),
        .pix   (pix)
    );

    blr_checker #(.GRID_SIZE(GRID_SIZE)) pixel_monitor
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .seg        (seg),
        .empty      (empty),
        .pop        (pop),
        .pix        (pix),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: pop high except for short random stalls
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    function automatic segment_t make_segment(input int xs, input int ys,
                                              input int xe, input int ye);
        segment_t s;
        s.x_start = COORD_W'(xs);
        s.y_start = COORD_W'(ys);
        s.x_end   = COORD_W'(xe);
        s.y_end   = COORD_W'(ye);
        return s;
    endfunction

    // mostly drawable segments, short ones favored, plus malformed ones
    function automatic segment_t random_segment();
        seg_kind_t kind;
        int        pick;
        int        dx;
        int        dy;
        int        xs;
        int        ys;
        segment_t  s;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            kind = SEG_OCTANT;
        else if (pick < 80)
            kind = SEG_NOISE;
        else if (pick < 86)
            kind = SEG_BACKWARD;
        else if (pick < 92)
            kind = SEG_DESCENDING;
        else
            kind = SEG_STEEP;
        s = SEG_W'($urandom);
        case (kind)
            SEG_OCTANT:
            begin
                dx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 12);
                dy = $urandom_range(0, dx);
                xs = $urandom_range(0, 63 - dx);
                ys = $urandom_range(0, 63 - dy);
                s  = make_segment(xs, ys, xs + dx, ys + dy);
            end
            SEG_BACKWARD:
            begin
                xs = $urandom_range(1, 63);
                s.x_start = COORD_W'(xs);
                s.x_end   = COORD_W'($urandom_range(0, xs - 1));
            end
            SEG_DESCENDING:
            begin
                ys = $urandom_range(1, 63);
                s.y_start = COORD_W'(ys);
                s.y_end   = COORD_W'($urandom_range(0, ys - 1));
            end
            SEG_STEEP:
            begin
                dx = $urandom_range(0, 62);
                dy = $urandom_range(dx + 1, 63);
                xs = $urandom_range(0, 63 - dx);
                ys = $urandom_range(0, 63 - dy);
                s  = make_segment(xs, ys, xs + dx, ys + dy);
            end
            default:
            begin
            end
        endcase
        return s;
    endfunction

    // hold the segment until the block takes it
    task automatic send_segment(input segment_t s);
        seg  <= s;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
    endtask

    // transfer a segment, then maybe leave a short gap
    task automatic feed_segment(input segment_t s);
        send_segment(s);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push  = 1'b0;
        seg   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, single points, ties and every kind of bad segment
        feed_segment(make_segment(0, 0, 63, 63));
        feed_segment(make_segment(0, 0, 63, 0));
        feed_segment(make_segment(0, 63, 63, 63));
        feed_segment(make_segment(63, 63, 63, 63));
        feed_segment(make_segment(0, 0, 0, 0));
        feed_segment(make_segment(5, 7, 5, 7));
        feed_segment(make_segment(0, 0, 63, 31));
        feed_segment(make_segment(1, 2, 62, 40));
        feed_segment(make_segment(0, 0, 2, 1));
        feed_segment(make_segment(0, 0, 4, 2));
        feed_segment(make_segment(32, 10, 40, 10));
        feed_segment(make_segment(10, 0, 9, 0));
        feed_segment(make_segment(0, 10, 20, 9));
        feed_segment(make_segment(0, 0, 5, 6));
        feed_segment(make_segment(63, 63, 0, 0));
        feed_segment(make_segment(0, 0, 0, 63));
        feed_segment(make_segment(0, 0, 62, 63));

        // random segments with stalls on both sides
        repeat (IDLE_ITEMS) feed_segment(random_segment());

        // back to back, no stalls
        idle_on = 1'b0;
        repeat (STEADY_ITEMS) feed_segment(random_segment());
        push <= 1'b0;

        // drain, then watch for stray results
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
